[rtl/i2rs_pkg.sv]
package i2rs_pkg;

  localparam int VALUE_WIDTH  = 32;
  localparam int STORE_DEPTH  = VALUE_WIDTH + 1;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
  localparam int STEP_W       = $clog2(VALUE_WIDTH);
  localparam int DIGIT_W      = 6;
  localparam int CHAR_W       = 7;

  localparam logic [7:0]        RADIX_MIN  = 8'd2;
  localparam logic [7:0]        RADIX_MAX  = 8'd36;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

  typedef struct packed {
    logic done;     // one-cycle pulse, quotient and remainder valid
    logic nonzero;  // quotient is not zero
  } div_stat_t;

  // remainder to ASCII, digits above 35 clamp to 'Z'
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] c;
    c = (d > 6'd35) ? 6'd35 : d;
    if (c < 6'd10) begin
      return CHAR_ZERO + CHAR_W'(c);
    end
    return CHAR_A + CHAR_W'(c - 6'd10);
  endfunction

endpackage

[rtl/i2rs_divider.sv]
module i2rs_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [i2rs_pkg::VALUE_WIDTH-1:0] dividend_i,
  input  logic [i2rs_pkg::DIGIT_W-1:0] base_i,
  output logic [i2rs_pkg::VALUE_WIDTH-1:0] quotient_o,
  output logic [i2rs_pkg::DIGIT_W-1:0] remainder_o,
  output i2rs_pkg::div_stat_t          stat_o
);
  import i2rs_pkg::*;

  // restoring long division, one quotient bit per cycle
  logic [VALUE_WIDTH-1:0] q_q, q_d;
  logic [DIGIT_W-1:0]     r_q, r_d;
  logic [DIGIT_W-1:0]     base_q;
  logic [STEP_W-1:0]      cnt_q;
  logic                   busy_q, nz_q, nz_d, done_q;
  logic [DIGIT_W:0]       trial;
  logic                   qbit;

  always_comb begin
    trial = {r_q, q_q[VALUE_WIDTH-1]};
    qbit  = (trial >= {1'b0, base_q});
    r_d   = qbit ? DIGIT_W'(trial - {1'b0, base_q}) : DIGIT_W'(trial);
    q_d   = {q_q[VALUE_WIDTH-2:0], qbit};
    nz_d  = nz_q | qbit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q    <= '0;
      r_q    <= '0;
      base_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      nz_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        q_q    <= dividend_i;
        r_q    <= '0;
        base_q <= base_i;
        cnt_q  <= '0;
        nz_q   <= 1'b0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        q_q   <= q_d;
        r_q   <= r_d;
        nz_q  <= nz_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_W'(VALUE_WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o     = q_q;
  assign remainder_o    = r_q;
  assign stat_o.done    = done_q;
  assign stat_o.nonzero = nz_q;

endmodule

[rtl/i2rs_digit_store.sv]
module i2rs_digit_store (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [i2rs_pkg::ADDR_W-1:0]  wr_addr_i,
  input  logic [i2rs_pkg::DIGIT_W-1:0] wr_data_i,
  input  logic                         rd_en_i,
  input  logic [i2rs_pkg::ADDR_W-1:0]  rd_addr_i,
  output logic [i2rs_pkg::DIGIT_W-1:0] rd_data_o
);
  import i2rs_pkg::*;

  // remainders, least significant first; contents undefined until written
  logic [DIGIT_W-1:0] mem_q [STORE_DEPTH];
  logic [DIGIT_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

[rtl/integer_to_radix_string_top.sv]
// Channel  Dir  Group        tdata (low bit up)              Side bands
// input    in   s_axis_*     value_bits[31:0] radix[39:32]   tuser=is_signed
// result   out  m_axis_*     char_code[6:0]                  tlast=last, tuser=error
//
// Flow: one item at a time. Each digit is computed in the bit-serial divider, then
// the sign and each digit character are loaded, a digit character taking a store
// read and then an output load; ready returns once the last character is loaded.
// A bad radix loads its error result from the error state, without dividing.
// Reset clears the registers; the digit store needs no clearing.
// A stall on the result side holds the output register and the emit sequencer;
// a new item is taken once the last character has reached the output register.
module integer_to_radix_string_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // value_bits[31:0], radix[39:32]
  input  logic        s_axis_tuser_i,   // is_signed
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // char_code[6:0]
  output logic        m_axis_tlast_o,   // last
  output logic        m_axis_tuser_o    // error
);
  import i2rs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_DIV,
    S_SIGN,
    S_READ,
    S_EMIT
  } state_e;

  state_e state_q;

  // input fields
  logic [31:0] in_value;
  logic        in_signed;
  logic [7:0]  in_radix;
  assign in_value  = s_axis_tdata_i[31:0];
  assign in_signed = s_axis_tuser_i;
  assign in_radix  = s_axis_tdata_i[39:32];

  logic                   in_accept, radix_bad, in_neg;
  logic [VALUE_WIDTH-1:0] in_raw, in_mag;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign radix_bad = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
  assign in_raw    = VALUE_WIDTH'(in_value);
  assign in_neg    = in_signed && in_raw[VALUE_WIDTH-1];
  assign in_mag    = in_neg ? (~in_raw + 1'b1) : in_raw;

  // divider and digit store
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend, div_quot;
  logic [DIGIT_W-1:0]     div_rem, rd_digit;
  div_stat_t              div_stat;
  logic [DIGIT_W-1:0]     base_q;
  logic [CNT_W-1:0]       n_q;
  logic                   neg_q;
  logic                   more_digits;
  logic                   st_wr, st_rd;

  // keep dividing while the quotient is non-zero and the store has room
  assign more_digits = div_stat.nonzero && ((n_q + 1'b1) < CNT_W'(STORE_DEPTH));
  assign div_start   = (in_accept && !radix_bad) ||
                       ((state_q == S_DIV) && div_stat.done && more_digits);
  assign div_dividend = in_accept ? in_mag : div_quot;
  assign st_wr = (state_q == S_DIV) && div_stat.done;
  assign st_rd = (state_q == S_READ);

  i2rs_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .base_i      (in_accept ? in_radix[DIGIT_W-1:0] : base_q),
    .quotient_o  (div_quot),
    .remainder_o (div_rem),
    .stat_o      (div_stat)
  );

  i2rs_digit_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr),
    .wr_addr_i (ADDR_W'(n_q)),
    .wr_data_i (div_rem),
    .rd_en_i   (st_rd),
    .rd_addr_i (ADDR_W'(n_q - 1'b1)),
    .rd_data_o (rd_digit)
  );

  // output register
  logic              out_valid_q, out_last_q, out_err_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_free, out_load;

  assign out_free = !out_valid_q || m_axis_tready_i;
  // a character is loaded whenever an emitting state finds the register free
  assign out_load = out_free &&
                    ((state_q == S_ERR) || (state_q == S_SIGN) || (state_q == S_EMIT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_char_q  <= CHAR_NONE;
      out_last_q  <= 1'b0;
      out_err_q   <= 1'b0;
      base_q      <= '0;
      n_q         <= '0;
      neg_q       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (radix_bad) begin
              state_q <= S_ERR;
            end else begin
              base_q  <= in_radix[DIGIT_W-1:0];
              neg_q   <= in_neg;
              n_q     <= '0;
              state_q <= S_DIV;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_char_q  <= CHAR_NONE;
            out_last_q  <= 1'b1;
            out_err_q   <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            n_q <= n_q + 1'b1;
            if (!more_digits) begin
              state_q <= neg_q ? S_SIGN : S_READ;
            end
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_char_q  <= CHAR_MINUS;
            out_last_q  <= 1'b0;
            out_err_q   <= 1'b0;
            state_q     <= S_READ;
          end
        end
        S_READ: begin
          // store read issued at n-1, data lands next cycle
          n_q     <= n_q - 1'b1;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_char_q  <= digit_char(rd_digit);
            out_last_q  <= (n_q == '0);
            out_err_q   <= 1'b0;
            state_q     <= (n_q == '0) ? S_IDLE : S_READ;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_err_q;

endmodule

[rtl/i2rs_checker.sv]
module i2rs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tuser_o
);
  import i2rs_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) &&
      $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while busy");

  // error result is a lone, empty item
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tlast_o && (m_axis_tdata_o == 8'h00))
    else $error("malformed error result");

  // plain results carry a digit, a letter or a sign
  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      ((m_axis_tdata_o >= 8'h30) && (m_axis_tdata_o <= 8'h39)) ||
      ((m_axis_tdata_o >= 8'h41) && (m_axis_tdata_o <= 8'h5A)) ||
      (m_axis_tdata_o == {1'b0, CHAR_MINUS}))
    else $error("bad character code");

  // sign is never the final character
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o == {1'b0, CHAR_MINUS}) |-> !m_axis_tlast_o)
    else $error("sign marked last");

endmodule

bind integer_to_radix_string_top i2rs_checker u_i2rs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

[tb/integer_to_radix_string_top_tb.sv]
module integer_to_radix_string_top_tb;
  import i2rs_pkg::*;

  localparam int HOLD_CYCLES  = 2500;   // long receiver hold-off
  localparam int QUIET_LIMIT  = 12000;  // cycles with no handshake at all
  localparam int RANDOM_NUMS  = 438;
  localparam int PACE_SPAN    = 30;     // items per pacing phase

  typedef struct {
    logic [31:0] value;
    logic        is_signed;
    logic [7:0]  radix;
  } num_item_t;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              err;
  } char_item_t;

  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic [39:0] s_data;
  logic        s_user;
  logic        m_ready;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;

  num_item_t  pending_nums[$];
  char_item_t expected_chars[$];
  num_item_t  next_num;
  int         nums_taken;
  int         quiet_cycles;
  int         hold_left;
  int         holds_done;
  int         mismatches;

  integer_to_radix_string_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic pace_e pace_now();
    return pace_e'((nums_taken / PACE_SPAN) % 4);
  endfunction

  function automatic logic send_pause();
    if (hold_left != 0) begin
      return 1'b0;  // keep offering while the receiver holds off
    end
    case (pace_now())
      PACE_SEND_IDLE: return $urandom_range(0, 99) < 53;
      PACE_BOTH:      return $urandom_range(0, 99) < 36;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic logic recv_stall();
    case (pace_now())
      PACE_RECV_STALL: return $urandom_range(0, 99) < 53;
      PACE_BOTH:       return $urandom_range(0, 99) < 36;
      default:         return 1'b0;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] ascii_digit(input logic [DIGIT_W-1:0] d);
    if (d < 6'd10) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_A + CHAR_W'(d - 6'd10);
  endfunction

  // expected characters for one number: sign first, then digits from the top
  task automatic predict_chars(input logic [31:0] value, input logic signed_mode,
                               input logic [7:0] radix);
    logic [31:0]        mag;
    logic [DIGIT_W-1:0] digits[$];
    logic [DIGIT_W-1:0] d;
    logic               neg;
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      expected_chars.push_back('{code: CHAR_NONE, last: 1'b1, err: 1'b1});
      return;
    end
    neg = signed_mode && value[31];
    mag = neg ? -value : value;
    do begin
      digits.push_back(DIGIT_W'(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    if (neg) begin
      expected_chars.push_back('{code: CHAR_MINUS, last: 1'b0, err: 1'b0});
    end
    while (digits.size() != 0) begin
      d = digits.pop_back();
      expected_chars.push_back('{code: ascii_digit(d), last: digits.size() == 0,
                                 err: 1'b0});
    end
  endtask

  task automatic check_char(input logic [CHAR_W-1:0] code, input logic last,
                            input logic err);
    char_item_t want;
    if (expected_chars.size() == 0) begin
      $error("unexpected item: char_code %h last %b error %b", code, last, err);
      mismatches++;
    end else begin
      want = expected_chars.pop_front();
      if (code !== want.code) begin
        $error("char_code: expected %h, actual %h", want.code, code);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %b, actual %b", want.last, last);
        mismatches++;
      end
      if (err !== want.err) begin
        $error("error: expected %b, actual %b", want.err, err);
        mismatches++;
      end
    end
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] corner;
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 255);
      1: return $urandom() >> $urandom_range(0, 31);
      2: begin
        case ($urandom_range(0, 3))
          0:       corner = 32'h8000_0000;
          1:       corner = 32'h7FFF_FFFF;
          2:       corner = 32'hFFFF_FFFF;
          default: corner = 32'h0000_0000;
        endcase
        return corner ^ 32'($urandom_range(0, 3));
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] pick_radix();
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        return 8'($urandom_range(0, 1));
      end
      return 8'($urandom_range(37, 255));
    end
    return 8'($urandom_range(2, 36));
  endfunction

  task automatic add_num(input logic [31:0] value, input logic signed_mode,
                         input logic [7:0] radix);
    pending_nums.push_back('{value: value, is_signed: signed_mode, radix: radix});
  endtask

  // driver: holds an offered item until it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      s_user  <= 1'b0;
    end else if (!s_valid || s_axis_tready_o) begin
      if (pending_nums.size() != 0 && !send_pause()) begin
        next_num = pending_nums.pop_front();
        s_data   <= {next_num.radix, next_num.value};
        s_user   <= next_num.is_signed;
        s_valid  <= 1'b1;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // receiver ready, with random stalls and occasional long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      m_ready   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && nums_taken >= 100 + 230 * holds_done) begin
      m_ready    <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      m_ready <= !recv_stall();
    end
  end

  // monitor: predicts on taken numbers, checks taken characters, watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nums_taken   <= 0;
      quiet_cycles <= 0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        predict_chars(s_data[31:0], s_user, s_data[39:32]);
        nums_taken <= nums_taken + 1;
      end
      if (m_axis_tvalid_o && m_ready) begin
        check_char(m_axis_tdata_o[CHAR_W-1:0], m_axis_tlast_o, m_axis_tuser_o);
      end
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("integer_to_radix_string_top_tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    mismatches = 0;

    // zero in several bases
    add_num(32'd0, 1'b0, 8'd10);
    add_num(32'd0, 1'b1, 8'd2);
    add_num(32'd0, 1'b0, 8'd36);
    // all ones: longest unsigned string, and -1 when signed
    add_num(32'hFFFF_FFFF, 1'b0, 8'd2);
    add_num(32'hFFFF_FFFF, 1'b0, 8'd16);
    add_num(32'hFFFF_FFFF, 1'b0, 8'd36);
    add_num(32'hFFFF_FFFF, 1'b1, 8'd10);
    // most negative signed value, the same bits unsigned, and the largest positive value
    add_num(32'h8000_0000, 1'b1, 8'd2);
    add_num(32'h8000_0000, 1'b1, 8'd10);
    add_num(32'h8000_0000, 1'b1, 8'd36);
    add_num(32'h8000_0000, 1'b0, 8'd16);
    add_num(32'h7FFF_FFFF, 1'b1, 8'd2);
    add_num(32'h7FFF_FFFF, 1'b1, 8'd10);
    // top digit, first carry into a second digit, ordinary values
    add_num(32'd35, 1'b0, 8'd36);
    add_num(32'd36, 1'b1, 8'd36);
    add_num(32'd12345, 1'b1, 8'd10);
    add_num(32'hDEAD_BEEF, 1'b0, 8'd16);
    add_num(32'hDEAD_BEEF, 1'b1, 8'd16);
    add_num(32'd1, 1'b1, 8'd2);
    // bad bases on both sides of the valid range
    add_num(32'hFFFF_FFFF, 1'b1, 8'd0);
    add_num(32'd5, 1'b0, 8'd1);
    add_num(32'h8000_0000, 1'b1, 8'd37);
    add_num(32'd77, 1'b0, 8'd128);
    add_num(32'hA5A5_5A5A, 1'b1, 8'd255);

    for (int i = 0; i < RANDOM_NUMS; i++) begin
      add_num(pick_value(), 1'($urandom_range(0, 1)), pick_radix());
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_nums.size() != 0 || s_valid || expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("integer_to_radix_string_top_tb: clean");
    end else begin
      $display("integer_to_radix_string_top_tb: errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/i2rs_pkg.sv
rtl/i2rs_divider.sv
rtl/i2rs_digit_store.sv
rtl/integer_to_radix_string_top.sv
rtl/i2rs_checker.sv
tb/integer_to_radix_string_top_tb.sv
